### hw/rtl/chroma_wedge_key_invert_unit_macros.svh
// Assertion helpers for the chroma wedge key block.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef CHROMA_WEDGE_KEY_INVERT_UNIT_MACROS_SVH
`define CHROMA_WEDGE_KEY_INVERT_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define CWK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define CWK_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define CWK_ASSERT(lbl, prop, msg)
`define CWK_NEVER(lbl, cond, msg)
`endif
`endif

### hw/rtl/cwk_pkg.sv
package cwk_pkg;

  localparam int unsigned TDATA_W    = 24;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 27;

  localparam logic signed [29:0] DIST_CLAMP_HI = 30'sd268435456;
  localparam logic [22:0]        SPILL_ONE     = 23'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_COS         = 3'd0,
    CFG_KEY_SIN         = 3'd1,
    CFG_WEDGE_SLOPE     = 3'd2,
    CFG_INVERSE_RANGE   = 3'd3,
    CFG_DISTANCE_OFFSET = 3'd4,
    CFG_SPILL_GAIN      = 3'd5,
    CFG_KEY_CHROMA      = 3'd6,
    CFG_SWAP_SELECTION  = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [13:0] key_cos;
    logic signed [13:0] key_sin;
    logic signed [26:0] wedge_slope;
    logic        [12:0] inverse_range;
    logic signed [21:0] distance_offset;
    logic        [12:0] spill_gain;
    logic        [15:0] key_chroma;
    logic               swap_selection;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    key_cos:         14'sd4096,
    key_sin:         14'sd0,
    wedge_slope:     27'sd7094,
    inverse_range:   13'd408,
    distance_offset: 22'sd0,
    spill_gain:      13'd0,
    key_chroma:      16'd0,
    swap_selection:  1'b0
  };

  // Pixel after rotation into the key frame
  typedef struct packed {
    logic        [7:0]  luma;
    logic signed [8:0]  uc;
    logic signed [8:0]  vc;
    logic signed [10:0] xx;
    logic        [9:0]  ayy;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

### hw/rtl/chroma_wedge_key_invert_unit.sv
// Channel   Direction  Handshake                  Payload
// s_axis    in         s_axis_tvalid/tready       tdata: luma, blue_diff, red_diff
// m_axis    out        m_axis_tvalid/tready       tdata: luma, blue_diff, red_diff
// cfg       in         cfg_valid/cfg_ready        cfg_index, cfg_data
//
// One pixel per clock sustained while m_axis accepts every result.
// The multipliers are fully pipelined, so they do not limit that rate.
// Reset loads the register defaults and empties every stage and the queue.
// A stalled m_axis freezes the back pipeline; the queue absorbs the front,
// and s_axis_tready_o falls once the queue and front register are full.
module chroma_wedge_key_invert_unit
  import cwk_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [TDATA_W-1:0]    s_axis_tdata_i,   // luma_in, blue_diff_in, red_diff_in
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [TDATA_W-1:0]    m_axis_tdata_o,   // luma_out, blue_diff_out, red_diff_out
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t       cfg_d, cfg_q;
  fifo_stat_t fifo_stat;
  item_t      front_item, back_item;
  logic       push, pop;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_KEY_COS:         cfg_d.key_cos         = $signed(cfg_data_i[13:0]);
        CFG_KEY_SIN:         cfg_d.key_sin         = $signed(cfg_data_i[13:0]);
        CFG_WEDGE_SLOPE:     cfg_d.wedge_slope     = $signed(cfg_data_i[26:0]);
        CFG_INVERSE_RANGE:   cfg_d.inverse_range   = cfg_data_i[12:0];
        CFG_DISTANCE_OFFSET: cfg_d.distance_offset = $signed(cfg_data_i[21:0]);
        CFG_SPILL_GAIN:      cfg_d.spill_gain      = cfg_data_i[12:0];
        CFG_KEY_CHROMA:      cfg_d.key_chroma      = cfg_data_i[15:0];
        CFG_SWAP_SELECTION:  cfg_d.swap_selection  = cfg_data_i[0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  cwk_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .fifo_stat_i     (fifo_stat),
    .push_o          (push),
    .item_o          (front_item)
  );

  cwk_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (front_item),
    .pop_i  (pop),
    .item_o (back_item),
    .stat_o (fifo_stat)
  );

  cwk_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .fifo_stat_i     (fifo_stat),
    .item_i          (back_item),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

### hw/rtl/cwk_front.sv
module cwk_front
  import cwk_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [TDATA_W-1:0] s_axis_tdata_i,
  input  fifo_stat_t         fifo_stat_i,
  output logic               push_o,
  output item_t              item_o
);

  logic               vld_d, vld_q;
  item_t              item_d, item_q;
  logic signed [8:0]  uc, vc;
  logic signed [22:0] rx, ry;
  logic signed [10:0] yy;
  logic               accept;

  always_comb begin
    uc = $signed({1'b0, s_axis_tdata_i[15:8]}) - 9'sd128;
    vc = $signed({1'b0, s_axis_tdata_i[23:16]}) - 9'sd128;
    rx = 23'(uc) * 23'(cfg_i.key_cos) + 23'(vc) * 23'(cfg_i.key_sin);
    ry = 23'(vc) * 23'(cfg_i.key_cos) - 23'(uc) * 23'(cfg_i.key_sin);
    yy = $signed(ry[22:12]);
    item_d.luma = s_axis_tdata_i[7:0];
    item_d.uc   = uc;
    item_d.vc   = vc;
    item_d.xx   = $signed(rx[22:12]);
    item_d.ayy  = yy[10] ? 10'(-yy) : yy[9:0];
  end

  assign s_axis_tready_o = !vld_q || !fifo_stat_i.full;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign push_o          = vld_q && !fifo_stat_i.full;
  assign item_o          = item_q;

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (push_o) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

### hw/rtl/cwk_fifo.sv
`include "chroma_wedge_key_invert_unit_macros.svh"

module cwk_fifo
  import cwk_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  item_t      item_i,
  input  logic       pop_i,
  output item_t      item_o,
  output fifo_stat_t stat_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  item_t             mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_d, wr_ptr_q, rd_ptr_d, rd_ptr_q;
  logic [CNT_W-1:0]  cnt_d, cnt_q;

  assign stat_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign item_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  `CWK_NEVER(a_fifo_overflow, push_i && stat_o.full, "transfer pushed into a full queue")
  `CWK_NEVER(a_fifo_underflow, pop_i && stat_o.empty, "transfer popped from an empty queue")
  `CWK_ASSERT(a_fifo_ptr_empty, (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q), "queue pointers diverge")

endmodule

### hw/rtl/cwk_back.sv
module cwk_back
  import cwk_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  fifo_stat_t         fifo_stat_i,
  input  item_t              item_i,
  output logic               pop_o,
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [TDATA_W-1:0] m_axis_tdata_o
);

  logic       adv;
  logic [4:0] stg_vld_d, stg_vld_q;
  logic       out_vld_d, out_vld_q;

  // stage 1: slope product, offset distance, spill product
  logic [7:0]  s1_luma_q;
  logic signed [8:0]  s1_uc_q, s1_vc_q;
  logic signed [36:0] s1_pslope_d, s1_pslope_q;
  logic signed [23:0] s1_dpart_d, s1_dpart_q;
  logic [22:0] s1_sp_d, s1_sp_q;
  logic        s1_xpos_d, s1_xpos_q;

  // stage 2: distance clamp, spill clamp
  logic [7:0]  s2_luma_q;
  logic signed [8:0]  s2_uc_q, s2_vc_q;
  logic signed [37:0] wedge_dist;
  logic signed [29:0] s2_dcl_d, s2_dcl_q;
  logic [12:0] s2_s_d, s2_s_q;

  // stage 3: alpha product, spill products
  logic [7:0]  s3_luma_q;
  logic signed [8:0]  s3_uc_q, s3_vc_q;
  logic signed [43:0] s3_aprod_d, s3_aprod_q;
  logic signed [20:0] s3_su_d, s3_su_q, s3_sv_d, s3_sv_q;

  // stage 4: alpha, suppressed chroma
  logic [7:0]  s4_luma_q;
  logic signed [23:0] ash;
  logic [7:0]  alpha_c;
  logic [7:0]  s4_alpha_d, s4_alpha_q;
  logic signed [9:0]  s4_cu_d, s4_cu_q, s4_cv_d, s4_cv_q;

  // stage 5: blend sums
  logic signed [9:0]  wy;
  logic signed [8:0]  alpha_s;
  logic signed [19:0] s5_by_d, s5_by_q, s5_bu_d, s5_bu_q, s5_bv_d, s5_bv_q;

  // output stage: rounding divide and clamp
  logic signed [20:0] dy, du, dv;
  logic signed [12:0] qy, qu, qv;
  logic [7:0]  oy_d, ou_d, ov_d, oy_q, ou_q, ov_q;

  assign adv   = !out_vld_q || m_axis_tready_i;
  assign pop_o = adv && !fifo_stat_i.empty;

  always_comb begin
    s1_pslope_d = 37'($signed({1'b0, item_i.ayy})) * 37'(cfg_i.wedge_slope);
    s1_dpart_d  = 24'(cfg_i.distance_offset) - (24'(item_i.xx) <<< 12);
    s1_xpos_d   = !item_i.xx[10] && (item_i.xx != '0);
    s1_sp_d     = s1_xpos_d ? 23'(item_i.xx[9:0]) * 23'(cfg_i.spill_gain) : '0;
  end

  always_comb begin
    wedge_dist = 38'(s1_dpart_q) + 38'(s1_pslope_q);
    if (wedge_dist[37]) begin
      s2_dcl_d = -30'sd1;
    end else if (wedge_dist > 38'(DIST_CLAMP_HI)) begin
      s2_dcl_d = DIST_CLAMP_HI;
    end else begin
      s2_dcl_d = wedge_dist[29:0];
    end
    if (!s1_xpos_q) begin
      s2_s_d = '0;
    end else if (s1_sp_q > SPILL_ONE) begin
      s2_s_d = SPILL_ONE[12:0];
    end else begin
      s2_s_d = s1_sp_q[12:0];
    end
  end

  always_comb begin
    s3_aprod_d = 44'(s2_dcl_q) * 44'($signed({1'b0, cfg_i.inverse_range}));
    s3_su_d    = 21'($signed({1'b0, s2_s_q})) * 21'($signed(cfg_i.key_chroma[7:0]));
    s3_sv_d    = 21'($signed({1'b0, s2_s_q})) * 21'($signed(cfg_i.key_chroma[15:8]));
  end

  always_comb begin
    ash = $signed(s3_aprod_q[43:20]);
    if (ash[23]) begin
      alpha_c = 8'd0;
    end else if (ash > 24'sd255) begin
      alpha_c = 8'd255;
    end else begin
      alpha_c = ash[7:0];
    end
    s4_alpha_d = cfg_i.swap_selection ? 8'd255 - alpha_c : alpha_c;
    s4_cu_d    = 10'(s3_uc_q) - 10'($signed(s3_su_q[20:12]));
    s4_cv_d    = 10'(s3_vc_q) - 10'($signed(s3_sv_q[20:12]));
  end

  always_comb begin
    alpha_s = $signed({1'b0, s4_alpha_q});
    wy      = 10'sd255 - (10'($signed({1'b0, s4_luma_q})) <<< 1);
    s5_by_d = 20'($signed({1'b0, s4_luma_q})) * 20'sd255 + 20'(wy) * 20'(alpha_s);
    s5_bu_d = 20'(s4_cu_q) * 20'sd255 - (20'(s4_cu_q) <<< 1) * 20'(alpha_s);
    s5_bv_d = 20'(s4_cv_q) * 20'sd255 - (20'(s4_cv_q) <<< 1) * 20'(alpha_s);
  end

  always_comb begin
    dy = 21'(s5_by_q) + 21'sd1 + 21'(s5_by_q >>> 8);
    du = 21'(s5_bu_q) + 21'sd1 + 21'(s5_bu_q >>> 8);
    dv = 21'(s5_bv_q) + 21'sd1 + 21'(s5_bv_q >>> 8);
    qy = $signed(dy[20:8]);
    qu = $signed(du[20:8]);
    qv = $signed(dv[20:8]);
    if (qy[12]) begin
      oy_d = 8'd0;
    end else if (qy > 13'sd255) begin
      oy_d = 8'd255;
    end else begin
      oy_d = qy[7:0];
    end
    if (qu < -13'sd128) begin
      ou_d = 8'd0;
    end else if (qu > 13'sd127) begin
      ou_d = 8'd255;
    end else begin
      ou_d = {~qu[7], qu[6:0]};
    end
    if (qv < -13'sd128) begin
      ov_d = 8'd0;
    end else if (qv > 13'sd127) begin
      ov_d = 8'd255;
    end else begin
      ov_d = {~qv[7], qv[6:0]};
    end
  end

  always_comb begin
    stg_vld_d = stg_vld_q;
    out_vld_d = out_vld_q;
    if (adv) begin
      stg_vld_d = {stg_vld_q[3:0], pop_o};
      out_vld_d = stg_vld_q[4];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      stg_vld_q <= stg_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_luma_q   <= item_i.luma;
      s1_uc_q     <= item_i.uc;
      s1_vc_q     <= item_i.vc;
      s1_pslope_q <= s1_pslope_d;
      s1_dpart_q  <= s1_dpart_d;
      s1_sp_q     <= s1_sp_d;
      s1_xpos_q   <= s1_xpos_d;

      s2_luma_q <= s1_luma_q;
      s2_uc_q   <= s1_uc_q;
      s2_vc_q   <= s1_vc_q;
      s2_dcl_q  <= s2_dcl_d;
      s2_s_q    <= s2_s_d;

      s3_luma_q  <= s2_luma_q;
      s3_uc_q    <= s2_uc_q;
      s3_vc_q    <= s2_vc_q;
      s3_aprod_q <= s3_aprod_d;
      s3_su_q    <= s3_su_d;
      s3_sv_q    <= s3_sv_d;

      s4_luma_q  <= s3_luma_q;
      s4_alpha_q <= s4_alpha_d;
      s4_cu_q    <= s4_cu_d;
      s4_cv_q    <= s4_cv_d;

      s5_by_q <= s5_by_d;
      s5_bu_q <= s5_bu_d;
      s5_bv_q <= s5_bv_d;

      oy_q <= oy_d;
      ou_q <= ou_d;
      ov_q <= ov_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {ov_q, ou_q, oy_q};

endmodule

### tb/key_blend_checker.sv
module key_blend_checker
  import cwk_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  input  logic                  s_axis_tready_i,
  input  logic [TDATA_W-1:0]    s_axis_tdata_i,   // luma, blue_diff, red_diff
  input  logic                  m_axis_tvalid_i,
  input  logic                  m_axis_tready_i,
  input  logic [TDATA_W-1:0]    m_axis_tdata_i,   // luma, blue_diff, red_diff
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROT_SHIFT   = 12;
  localparam int ALPHA_SHIFT = 20;
  localparam longint UNITY   = 4096;
  localparam longint MID     = 128;
  localparam longint FULL    = 255;

  typedef struct packed {
    logic [7:0] red_diff;
    logic [7:0] blue_diff;
    logic [7:0] luma;
  } pixel_t;

  cfg_t   key_cfg;
  pixel_t expected_pixels[$];
  pixel_t got;
  pixel_t want;
  int     mismatch_count;
  int     checked;

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint div255(longint x);
    return (x + 1 + (x >>> 8)) >>> 8;
  endfunction

  function automatic pixel_t predict_keyed_pixel(cfg_t c, pixel_t p);
    longint kc, ks, slope, irange, offs, gain, ku, kv;
    longint y, uc, vc, xx, yy, ayy, wedge_dist, alpha, cu, cv, s;
    pixel_t r;
    kc     = longint'($signed(c.key_cos));
    ks     = longint'($signed(c.key_sin));
    slope  = longint'($signed(c.wedge_slope));
    irange = longint'(c.inverse_range);
    offs   = longint'($signed(c.distance_offset));
    gain   = longint'(c.spill_gain);
    ku     = longint'($signed(c.key_chroma[7:0]));
    kv     = longint'($signed(c.key_chroma[15:8]));
    y      = longint'(p.luma);
    uc     = longint'(p.blue_diff) - MID;
    vc     = longint'(p.red_diff) - MID;
    xx     = (uc * kc + vc * ks) >>> ROT_SHIFT;
    yy     = (vc * kc - uc * ks) >>> ROT_SHIFT;
    ayy    = (yy < 0) ? -yy : yy;
    wedge_dist = offs - xx * UNITY + ayy * slope;
    alpha  = clamp((wedge_dist * irange) >>> ALPHA_SHIFT, 0, FULL);
    if (c.swap_selection) alpha = FULL - alpha;
    cu = uc;
    cv = vc;
    if (xx > 0) begin
      s = xx * gain;
      if (s > UNITY) s = UNITY;
      cu = cu - ((s * ku) >>> ROT_SHIFT);
      cv = cv - ((s * kv) >>> ROT_SHIFT);
    end
    r.luma      = 8'(clamp(div255(y * FULL + ((FULL - y) - y) * alpha), 0, FULL));
    r.blue_diff = 8'(clamp(div255(cu * FULL - 2 * cu * alpha), -128, 127) + MID);
    r.red_diff  = 8'(clamp(div255(cv * FULL - 2 * cv * alpha), -128, 127) + MID);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_cfg = CFG_RESET;
      expected_pixels.delete();
      mismatch_count = 0;
      checked = 0;
      fail_count_o <= 0;
      pending_o <= 0;
      checked_o <= 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = m_axis_tdata_i;
        if (expected_pixels.size() == 0) begin
          $error("unexpected result transfer %h with no pixel outstanding", got);
          mismatch_count++;
        end else begin
          want = expected_pixels.pop_front();
          checked++;
          if (got.luma !== want.luma) begin
            $error("luma_out mismatch: expected %0d, got %0d", want.luma, got.luma);
            mismatch_count++;
          end
          if (got.blue_diff !== want.blue_diff) begin
            $error("blue_diff_out mismatch: expected %0d, got %0d",
                   want.blue_diff, got.blue_diff);
            mismatch_count++;
          end
          if (got.red_diff !== want.red_diff) begin
            $error("red_diff_out mismatch: expected %0d, got %0d",
                   want.red_diff, got.red_diff);
            mismatch_count++;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        expected_pixels.push_back(predict_keyed_pixel(key_cfg, pixel_t'(s_axis_tdata_i)));
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_KEY_COS:         key_cfg.key_cos         = cfg_data_i[13:0];
          CFG_KEY_SIN:         key_cfg.key_sin         = cfg_data_i[13:0];
          CFG_WEDGE_SLOPE:     key_cfg.wedge_slope     = cfg_data_i[26:0];
          CFG_INVERSE_RANGE:   key_cfg.inverse_range   = cfg_data_i[12:0];
          CFG_DISTANCE_OFFSET: key_cfg.distance_offset = cfg_data_i[21:0];
          CFG_SPILL_GAIN:      key_cfg.spill_gain      = cfg_data_i[12:0];
          CFG_KEY_CHROMA:      key_cfg.key_chroma      = cfg_data_i[15:0];
          CFG_SWAP_SELECTION:  key_cfg.swap_selection  = cfg_data_i[0];
          default: ;
        endcase
      end
      fail_count_o <= mismatch_count;
      pending_o <= expected_pixels.size();
      checked_o <= checked;
    end
  end

endmodule

### tb/testbench.sv
module testbench
  import cwk_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 20;
  localparam int LIMIT_CYCLES  = 500000;
  localparam int ROUNDS        = 8;
  localparam int ROUND_PIXELS  = 250;
  localparam int CFG_W         = $bits(cfg_t);

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [TDATA_W-1:0]    s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]    m_axis_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int   fail_count;
  int   pending;
  int   checked;
  int   cycle_count = 0;
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  int   settings_count = 0;
  cfg_t active_setting = CFG_RESET;

  chroma_wedge_key_invert_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  key_blend_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .checked_o       (checked)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= rst_ni && ($urandom_range(99) >= rx_idle_pct);
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [7:0] sat8(int v);
    return (v < 0) ? 8'd0 : ((v > 255) ? 8'd255 : 8'(v));
  endfunction

  function automatic logic [7:0] corner_value();
    case ($urandom_range(6))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd127;
      3:       return 8'd128;
      4:       return 8'd129;
      5:       return 8'd254;
      default: return 8'd255;
    endcase
  endfunction

  function automatic logic [23:0] corner_pixel(int k);
    case (k)
      0:       return {8'd128, 8'd128, 8'd0};
      1:       return {8'd128, 8'd128, 8'd255};
      2:       return {8'd0,   8'd0,   8'd0};
      3:       return {8'd255, 8'd255, 8'd255};
      4:       return {8'd255, 8'd0,   8'd128};
      5:       return {8'd0,   8'd255, 8'd128};
      6:       return {8'd255, 8'd255, 8'd17};
      default: return {8'd0,   8'd0,   8'd200};
    endcase
  endfunction

  function automatic cfg_t random_settings(bit raw);
    cfg_t s;
    if (raw) begin
      s = CFG_W'({$urandom(), $urandom(), $urandom(), $urandom()});
    end else begin
      s.key_cos         = 14'(int'($urandom_range(8192)) - 4096);
      s.key_sin         = 14'(int'($urandom_range(8192)) - 4096);
      s.wedge_slope     = 27'(int'($urandom_range(40000)) - 8000);
      s.inverse_range   = 13'($urandom_range(8191));
      s.distance_offset = 22'(int'($urandom_range(2097152)) - 1048576);
      s.spill_gain      = 13'($urandom_range(4096));
      s.key_chroma      = 16'($urandom_range(65535));
      s.swap_selection  = 1'($urandom_range(1));
    end
    return s;
  endfunction

  task automatic send_pixel(input logic [23:0] pixel);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pixel;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic send_random_pixel();
    int r, kc, ks;
    logic [7:0] y, cb, cr;
    y = 8'($urandom_range(255));
    case ($urandom_range(9))
      6, 7: begin
        kc = int'($signed(active_setting.key_cos));
        ks = int'($signed(active_setting.key_sin));
        r  = $urandom_range(181);
        cb = sat8(128 + (r * kc) / 4096 + int'($urandom_range(16)) - 8);
        cr = sat8(128 + (r * ks) / 4096 + int'($urandom_range(16)) - 8);
      end
      8, 9: begin
        y  = corner_value();
        cb = corner_value();
        cr = corner_value();
      end
      default: begin
        cb = 8'($urandom_range(255));
        cr = 8'($urandom_range(255));
      end
    endcase
    send_pixel({cr, cb, y});
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
  endtask

  // pad narrow registers with junk above their width
  task automatic apply_settings(input cfg_t s);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom());
    write_reg(CFG_KEY_COS,         {junk[26:14], s.key_cos});
    write_reg(CFG_KEY_SIN,         {junk[26:14], s.key_sin});
    write_reg(CFG_WEDGE_SLOPE,     s.wedge_slope);
    write_reg(CFG_INVERSE_RANGE,   {junk[26:13], s.inverse_range});
    write_reg(CFG_DISTANCE_OFFSET, {junk[26:22], s.distance_offset});
    write_reg(CFG_SPILL_GAIN,      {junk[26:13], s.spill_gain});
    write_reg(CFG_KEY_CHROMA,      {junk[26:16], s.key_chroma});
    write_reg(CFG_SWAP_SELECTION,  {junk[26:1], s.swap_selection});
    cfg_valid <= 1'b0;
    active_setting = s;
    settings_count++;
  endtask

  initial begin
    cfg_t extreme;
    int k;
    int round;
    int n;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (k = 0; k < 8; k++) send_pixel(corner_pixel(k));
    drain();

    extreme.key_cos         = 14'sd4096;
    extreme.key_sin         = -14'sd4096;
    extreme.wedge_slope     = 27'sd40960000;
    extreme.inverse_range   = 13'd8191;
    extreme.distance_offset = 22'sd1048576;
    extreme.spill_gain      = 13'd4096;
    extreme.key_chroma      = 16'h807F;
    extreme.swap_selection  = 1'b1;
    apply_settings(extreme);
    for (k = 0; k < 8; k++) send_pixel(corner_pixel(k));
    drain();

    extreme.key_cos         = 14'h2000;
    extreme.key_sin         = 14'h1FFF;
    extreme.wedge_slope     = 27'h4000000;
    extreme.inverse_range   = 13'd8191;
    extreme.distance_offset = 22'h200000;
    extreme.spill_gain      = 13'd8191;
    extreme.key_chroma      = 16'h7F80;
    extreme.swap_selection  = 1'b0;
    apply_settings(extreme);
    for (k = 0; k < 8; k++) send_pixel(corner_pixel(k));

    for (round = 0; round < ROUNDS; round++) begin
      if (round < 3) begin
        tx_idle_pct = 16;
        rx_idle_pct = 87;
      end else if (round < 6) begin
        tx_idle_pct = 87;
        rx_idle_pct = 16;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      drain();
      apply_settings(random_settings(round == 2 || round == 5));
      for (n = 0; n < ROUND_PIXELS; n++) begin
        if (n == ROUND_PIXELS / 2) drain();
        send_random_pixel();
      end
    end
    drain();

    $display("Checked %0d pixels across %0d register settings", checked, settings_count);
    $display("Covered corner pixels, extreme and raw registers, and three stall mixes");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
